@@ rtl/hrbf_pkg.sv @@
`default_nettype none
package hrbf_pkg;
	localparam int LENGTH_BITS_DEF = 32;
	localparam int FIFO_DEPTH = 4;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_FIXED = 2'd1;
	localparam logic [1:0] PH_CHUNK = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_HEX = 2'd1;
	localparam logic [1:0] ERR_OVF = 2'd2;

	// one classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic start_new;
		logic is_cr;
		logic is_lf;
		logic is_dig;
		logic is_hex;
		logic [3:0] nib;
	} item_t;

	function automatic logic [7:0] cl_char(input logic [4:0] i);
		case (i)
			5'd0: cl_char = "C";
			5'd1: cl_char = "o";
			5'd2: cl_char = "n";
			5'd3: cl_char = "t";
			5'd4: cl_char = "e";
			5'd5: cl_char = "n";
			5'd6: cl_char = "t";
			5'd7: cl_char = "-";
			5'd8: cl_char = "L";
			5'd9: cl_char = "e";
			5'd10: cl_char = "n";
			5'd11: cl_char = "g";
			5'd12: cl_char = "t";
			5'd13: cl_char = "h";
			5'd14: cl_char = ":";
			5'd15: cl_char = " ";
			default: cl_char = 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] te_char(input logic [4:0] i);
		case (i)
			5'd0: te_char = "T";
			5'd1: te_char = "r";
			5'd2: te_char = "a";
			5'd3: te_char = "n";
			5'd4: te_char = "s";
			5'd5: te_char = "f";
			5'd6: te_char = "e";
			5'd7: te_char = "r";
			5'd8: te_char = "-";
			5'd9: te_char = "E";
			5'd10: te_char = "n";
			5'd11: te_char = "c";
			5'd12: te_char = "o";
			5'd13: te_char = "d";
			5'd14: te_char = "i";
			5'd15: te_char = "n";
			5'd16: te_char = "g";
			5'd17: te_char = ":";
			5'd18: te_char = " ";
			default: te_char = 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] ck_char(input logic [2:0] i);
		case (i)
			3'd0: ck_char = "c";
			3'd1: ck_char = "h";
			3'd2: ck_char = "u";
			3'd3: ck_char = "n";
			3'd4: ck_char = "k";
			3'd5: ck_char = "e";
			3'd6: ck_char = "d";
			default: ck_char = 8'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

@@ rtl/hrbf_front.sv @@
`default_nettype none
module hrbf_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] in_byte,
	input wire logic in_start,
	output logic q_valid,
	input wire logic q_ready,
	output hrbf_pkg::item_t q_item
);
	// classify input byte into a register stage
	logic v_s1;
	hrbf_pkg::item_t it_s1;
	logic [7:0] b;
	logic dig, lo, up;

	assign b = in_byte;
	assign dig = (b >= 8'h30) && (b <= 8'h39);
	assign lo = (b >= 8'h61) && (b <= 8'h66);
	assign up = (b >= 8'h41) && (b <= 8'h46);
	assign in_ready = !v_s1 || q_ready;
	assign q_valid = v_s1;
	assign q_item = it_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			it_s1.data <= b;
			it_s1.start_new <= in_start;
			it_s1.is_cr <= (b == 8'h0d);
			it_s1.is_lf <= (b == 8'h0a);
			it_s1.is_dig <= dig;
			it_s1.is_hex <= dig || lo || up;
			it_s1.nib <= dig ? b[3:0] : 4'(b[3:0] + 4'd9);
		end
	end
endmodule
`default_nettype wire

@@ rtl/hrbf_fifo.sv @@
`default_nettype none
module hrbf_fifo #(
	parameter int DEPTH = hrbf_pkg::FIFO_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic w_valid,
	output logic w_ready,
	input wire hrbf_pkg::item_t w_item,
	output logic r_valid,
	input wire logic r_ready,
	output hrbf_pkg::item_t r_item
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	hrbf_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign w_ready = (cnt_q != (AW+1)'(DEPTH));
	assign r_valid = (cnt_q != '0);
	assign r_item = mem_q[rp_q];
	assign wr = w_valid && w_ready;
	assign rd = r_valid && r_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : AW'(wp_q + 1'b1);
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : AW'(rp_q + 1'b1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= w_item;
	end
endmodule
`default_nettype wire

@@ rtl/hrbf_back.sv @@
`default_nettype none
module hrbf_back #(
	parameter int LENGTH_BITS = hrbf_pkg::LENGTH_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire hrbf_pkg::item_t q_item,
	output logic o_valid,
	input wire logic o_ready,
	output logic [15:0] o_data
);
	localparam logic [1:0] LM_KEY = 2'd0;
	localparam logic [1:0] LM_CLVAL = 2'd1;
	localparam logic [1:0] LM_TEVAL = 2'd2;
	localparam logic [1:0] LM_SKIP = 2'd3;
	localparam logic [1:0] CS_SIZE = 2'd0;
	localparam logic [1:0] CS_DATA = 2'd1;
	localparam logic [1:0] CS_CRLF = 2'd2;
	localparam logic [1:0] CS_TRAIL = 2'd3;
	localparam logic [LENGTH_BITS-1:0] LMAX = '1;

	logic [1:0] phase_q, kind_q, crlf_q, csub_q, err_q, mode_q;
	logic [4:0] lpos_q;
	logic [2:0] vpos_q;
	logic key_q;
	logic [LENGTH_BITS-1:0] acc_q, left_q;

	logic [1:0] phase_n, kind_n, crlf_n, csub_n, err_n, mode_n;
	logic [4:0] lpos_n;
	logic [2:0] vpos_n;
	logic key_n;
	logic [LENGTH_BITS-1:0] acc_n, left_n;
	logic bv, hd, rd;
	logic [1:0] ph0, kd0, cp0, cs0, er0, md0;
	logic [4:0] lp0;
	logic [2:0] vp0;
	logic ky0;
	logic [LENGTH_BITS-1:0] ac0, lf0;
	logic [LENGTH_BITS+3:0] m10;
	logic [7:0] b;
	logic take;
	logic line_end, hdr_end;
	logic [4:0] klen;
	logic [7:0] kch;

	assign q_ready = !o_valid || o_ready;
	assign take = q_valid && q_ready;
	assign b = q_item.data;

	function automatic logic [1:0] crlf_step(input logic cr, input logic lf,
		input logic [1:0] p);
		if (cr) crlf_step = (p == 2'd2) ? 2'd3 : 2'd1;
		else if (lf) crlf_step = (p == 2'd1 || p == 2'd3) ? 2'd2 : 2'd0;
		else crlf_step = 2'd0;
	endfunction

	always_comb begin
		ph0 = q_item.start_new ? hrbf_pkg::PH_HEADER : phase_q;
		kd0 = q_item.start_new ? 2'd0 : kind_q;
		cp0 = q_item.start_new ? 2'd0 : crlf_q;
		cs0 = q_item.start_new ? CS_SIZE : csub_q;
		er0 = q_item.start_new ? hrbf_pkg::ERR_NONE : err_q;
		md0 = q_item.start_new ? LM_KEY : mode_q;
		lp0 = q_item.start_new ? 5'd0 : lpos_q;
		vp0 = q_item.start_new ? 3'd0 : vpos_q;
		ky0 = q_item.start_new ? 1'b0 : key_q;
		ac0 = q_item.start_new ? '0 : acc_q;
		lf0 = q_item.start_new ? '0 : left_q;
		phase_n = ph0; kind_n = kd0; crlf_n = cp0; csub_n = cs0; err_n = er0;
		mode_n = md0; lpos_n = lp0; vpos_n = vp0; key_n = ky0;
		acc_n = ac0; left_n = lf0;
		bv = 1'b0; hd = 1'b0; rd = 1'b0;
		klen = ky0 ? 5'd19 : 5'd16;
		kch = ky0 ? hrbf_pkg::te_char(lp0) : hrbf_pkg::cl_char(lp0);
		m10 = {4'd0, ac0} * (LENGTH_BITS+4)'(10) + (LENGTH_BITS+4)'(b[3:0]);
		line_end = q_item.is_lf && (cp0 == 2'd1 || cp0 == 2'd3);
		hdr_end = q_item.is_lf && (cp0 == 2'd3);
		case (ph0)
			hrbf_pkg::PH_HEADER: begin
				crlf_n = crlf_step(q_item.is_cr, q_item.is_lf, cp0);
				if (line_end) begin
					if (kd0 == 2'd0) begin
						if (md0 == LM_CLVAL) kind_n = 2'd1;
						else if (md0 == LM_TEVAL && vp0 == 3'd7) kind_n = 2'd2;
					end
					mode_n = LM_KEY; lpos_n = '0; vpos_n = '0;
				end else begin
					case (md0)
						LM_KEY: begin
							if (lp0 == 5'd0) begin
								if (b == "C") begin key_n = 1'b0; lpos_n = 5'd1; end
								else if (b == "T") begin key_n = 1'b1; lpos_n = 5'd1; end
								else mode_n = LM_SKIP;
							end else if (b == kch) begin
								lpos_n = lp0 + 5'd1;
								if (lpos_n == klen) begin
									if (kd0 != 2'd0) mode_n = LM_SKIP;
									else begin
										mode_n = ky0 ? LM_TEVAL : LM_CLVAL;
										vpos_n = '0; acc_n = '0;
									end
								end
							end else mode_n = LM_SKIP;
						end
						LM_CLVAL: begin
							if (vp0 == 3'd0) begin
								if (q_item.is_dig) begin
									if (er0 != hrbf_pkg::ERR_OVF) begin
										if (m10[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
											err_n = hrbf_pkg::ERR_OVF; acc_n = LMAX;
										end else acc_n = m10[LENGTH_BITS-1:0];
									end
								end else vpos_n = 3'd1;
							end
						end
						LM_TEVAL: begin
							if (vp0 < 3'd7) begin
								if (b == hrbf_pkg::ck_char(vp0)) vpos_n = vp0 + 3'd1;
								else vpos_n = (b == "c") ? 3'd1 : 3'd0;
							end
						end
						default: ;
					endcase
				end
				if (hdr_end) begin
					hd = 1'b1; crlf_n = 2'd0;
					if (kind_n == 2'd1 && err_n == hrbf_pkg::ERR_NONE && acc_n != '0) begin
						left_n = acc_n; phase_n = hrbf_pkg::PH_FIXED;
					end else if (kind_n == 2'd2) begin
						acc_n = '0; csub_n = CS_SIZE; phase_n = hrbf_pkg::PH_CHUNK;
					end else begin
						phase_n = hrbf_pkg::PH_DONE; rd = 1'b1;
					end
				end
			end
			hrbf_pkg::PH_FIXED: begin
				bv = 1'b1;
				if (lf0 <= LENGTH_BITS'(1)) begin
					left_n = '0; phase_n = hrbf_pkg::PH_DONE; rd = 1'b1;
				end else left_n = lf0 - LENGTH_BITS'(1);
			end
			hrbf_pkg::PH_CHUNK: begin
				case (cs0)
					CS_SIZE: begin
						if (cp0 == 2'd1) begin
							if (q_item.is_lf) begin
								if (ac0 == '0) begin csub_n = CS_TRAIL; crlf_n = 2'd2; end
								else begin left_n = ac0; csub_n = CS_DATA; crlf_n = 2'd0; end
							end else begin
								err_n = hrbf_pkg::ERR_HEX; phase_n = hrbf_pkg::PH_DONE; rd = 1'b1;
							end
						end else if (q_item.is_cr) crlf_n = 2'd1;
						else if (q_item.is_hex) begin
							if (ac0[LENGTH_BITS-1 -: 4] != 4'd0) begin
								err_n = hrbf_pkg::ERR_OVF; phase_n = hrbf_pkg::PH_DONE; rd = 1'b1;
							end else acc_n = {ac0[LENGTH_BITS-5:0], q_item.nib};
						end else begin
							err_n = hrbf_pkg::ERR_HEX; phase_n = hrbf_pkg::PH_DONE; rd = 1'b1;
						end
					end
					CS_DATA: begin
						bv = 1'b1;
						if (lf0 <= LENGTH_BITS'(1)) begin
							left_n = '0; csub_n = CS_CRLF; crlf_n = 2'd0;
						end else left_n = lf0 - LENGTH_BITS'(1);
					end
					CS_CRLF: begin
						if (q_item.is_lf && cp0 == 2'd1) begin
							csub_n = CS_SIZE; acc_n = '0; crlf_n = 2'd0;
						end else crlf_n = q_item.is_cr ? 2'd1 : 2'd0;
					end
					default: begin
						crlf_n = crlf_step(q_item.is_cr, q_item.is_lf, cp0);
						if (q_item.is_lf && cp0 == 2'd3) begin
							crlf_n = 2'd0; phase_n = hrbf_pkg::PH_DONE; rd = 1'b1;
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrbf_pkg::PH_HEADER; kind_q <= '0; crlf_q <= '0;
			csub_q <= CS_SIZE; err_q <= hrbf_pkg::ERR_NONE; mode_q <= LM_KEY;
			lpos_q <= '0; vpos_q <= '0; key_q <= 1'b0; acc_q <= '0; left_q <= '0;
			o_valid <= 1'b0; o_data <= '0;
		end else begin
			if (q_ready) o_valid <= q_valid;
			if (take) begin
				phase_q <= phase_n; kind_q <= kind_n; crlf_q <= crlf_n;
				csub_q <= csub_n; err_q <= err_n; mode_q <= mode_n;
				lpos_q <= lpos_n; vpos_q <= vpos_n; key_q <= key_n;
				acc_q <= acc_n; left_q <= left_n;
				o_data <= {1'b0, err_n, rd, hd, phase_n, bv ? b : 8'd0, bv};
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/http_request_body_framer.sv @@
`default_nettype none
// channel  dir  tdata                                   tuser
// s_axis   in   [7:0] data_byte                         [0] start_new
// m_axis   out  [0] body_valid [8:1] body_byte          -
//               [10:9] phase [11] header_done
//               [12] request_done [14:13] error [15] 0
// one byte per clock sustained while m_axis does not stall; the path from s_axis to m_axis
// is registered in the classify stage, the queue and the framing state register
// arst_n clears all framing state to the header phase
// m_axis stalls fill the queue; s_axis_tready drops when it is full
module http_request_body_framer #(
	parameter int LENGTH_BITS = hrbf_pkg::LENGTH_BITS_DEF,
	parameter int FIFO_DEPTH = hrbf_pkg::FIFO_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata, // [7:0] data_byte
	input wire logic s_axis_tuser, // [0] start_new
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [15:0] m_axis_tdata // body_valid, body_byte, phase, header_done, request_done, error
);
	// classified transaction between front and queue
	logic f_valid, f_ready, b_valid, b_ready;
	hrbf_pkg::item_t f_item, b_item;

	hrbf_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_byte(s_axis_tdata), .in_start(s_axis_tuser),
		.q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
	);

	// decouples classification from framing
	hrbf_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.w_valid(f_valid), .w_ready(f_ready), .w_item(f_item),
		.r_valid(b_valid), .r_ready(b_ready), .r_item(b_item)
	);

	hrbf_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
		.o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_data(m_axis_tdata)
	);
endmodule
`default_nettype wire

@@ rtl/hrbf_checker.sv @@
`default_nettype none
module hrbf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);
	// a payload byte is only flagged in a body phase or on completion
	ap_body: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[10:9] != 2'd0)
		else $error("body byte in header phase");
	// header end always leaves the header phase
	ap_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[10:9] != 2'd0)
		else $error("header end without phase change");
	// request completion reports the complete phase
	ap_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[10:9] == 2'd3)
		else $error("request done outside complete phase");
	// error code is never three
	ap_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[14:13] != 2'd3)
		else $error("bad error code");
	// a stalled result transaction holds until taken
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
endmodule

bind http_request_body_framer hrbf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
